// ===== sv/hfrp_pkg.sv =====
package hfrp_pkg;

    // Queue between parser and output stage
    localparam int HFRP_QUEUE_DEPTH = 2;

    // Prefix masks and representation patterns of the first byte
    localparam logic [7:0] SIZE_UPD_MASK = 8'he0;
    localparam logic [7:0] SIZE_UPD_PAT  = 8'h20;
    localparam logic [7:0] INDEXED_BIT   = 8'h80;
    localparam logic [7:0] INCR_MASK     = 8'hc0;
    localparam logic [7:0] INCR_PAT      = 8'h40;
    localparam logic [7:0] PREFIX7_MASK  = 8'h7f;
    localparam logic [7:0] PREFIX6_MASK  = 8'h3f;
    localparam logic [7:0] PREFIX5_MASK  = 8'h1f;
    localparam logic [7:0] PREFIX4_MASK  = 8'h0f;

    // Continuation groups allowed before overflow
    localparam logic [2:0] MAX_CONT = 3'd5;

    typedef enum logic [2:0] {
        EV_SIZE_UPDATE = 3'd0,
        EV_INDEXED     = 3'd1,
        EV_LITERAL     = 3'd2,
        EV_NAME_START  = 3'd3,
        EV_NAME_BYTE   = 3'd4,
        EV_VALUE_START = 3'd5,
        EV_VALUE_BYTE  = 3'd6,
        EV_ERROR       = 3'd7
    } hfrp_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_TRUNCATED  = 2'd1,
        ERR_ZERO_INDEX = 2'd2,
        ERR_OVERFLOW   = 2'd3
    } hfrp_err_t;

    typedef enum logic [1:0] {
        REP_SIZE_UPDATE = 2'd0,
        REP_INDEXED     = 2'd1,
        REP_INCR        = 2'd2,
        REP_NO_INDEX    = 2'd3
    } hfrp_rep_t;

    // One parsed event, front to back
    typedef struct packed {
        hfrp_kind_t  kind;
        logic [31:0] value;
        logic        add;
        logic        huf;
        logic        last;
        logic        hdone;
        hfrp_err_t   err;
        logic        blk_end;
    } hfrp_event_t;

    // Queue status: full is seen by the front, valid by the back
    typedef struct packed {
        logic full;
        logic valid;
    } hfrp_q_status_t;

endpackage

// ===== sv/hfrp_in_if.sv =====
interface hfrp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

// ===== sv/hfrp_out_if.sv =====
interface hfrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [31:0] out_value;
    logic        add_to_table;
    logic        huffman_coded;
    logic        last_of_string;
    logic        header_done;
    logic        block_done;
    logic [1:0]  error_code;

    modport source (output valid, output event_kind, output out_value, output add_to_table,
                    output huffman_coded, output last_of_string, output header_done,
                    output block_done, output error_code, input ready);
    modport sink   (input valid, input event_kind, input out_value, input add_to_table,
                    input huffman_coded, input last_of_string, input header_done,
                    input block_done, input error_code, output ready);
endinterface

// ===== sv/hfrp_front.sv =====
module hfrp_front (
    input  logic                    clk,
    input  logic                    rst_n,
    hfrp_in_if.sink                 in_ch,
    input  logic                    q_full,
    output logic                    push,
    output hfrp_pkg::hfrp_event_t   push_event
);
    import hfrp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_REP   = 3'd1,
        PH_NLEN1 = 3'd2,
        PH_NLEN  = 3'd3,
        PH_NAME  = 3'd4,
        PH_VLEN1 = 3'd5,
        PH_VLEN  = 3'd6,
        PH_VALUE = 3'd7
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    hfrp_rep_t   rkind_reg, rkind_next;
    logic        add_reg, add_next;
    logic        huf_reg, huf_next;
    logic [31:0] remain_reg, remain_next;
    logic        discard_reg, discard_next;

    logic        accept;
    logic [7:0]  b;
    logic        blk_end;
    logic [7:0]  mask;
    logic [4:0]  shamt;
    logic [35:0] sum;
    logic        do_rep, do_len, len_name;
    logic [31:0] v;
    logic [31:0] rem_dec;
    hfrp_event_t ev;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data_byte;
    assign blk_end     = in_ch.block_end;

    assign shamt = 5'({2'b00, cnt_reg} * 5'd7);
    assign sum   = {4'b0000, acc_reg} + (36'(b[6:0]) << shamt);

    always_comb
    begin
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        rkind_next   = rkind_reg;
        add_next     = add_reg;
        huf_next     = huf_reg;
        remain_next  = remain_reg;
        discard_next = discard_reg;
        mask         = PREFIX4_MASK;
        do_rep       = 1'b0;
        do_len       = 1'b0;
        len_name     = 1'b0;
        v            = acc_reg;
        rem_dec      = remain_reg;
        ev           = '0;
        ev.kind      = EV_SIZE_UPDATE;
        ev.err       = ERR_NONE;
        ev.blk_end   = blk_end;

        if (discard_reg)
        begin
            if (blk_end)
            begin
                discard_next = 1'b0;
                phase_next   = PH_IDLE;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if ((b & SIZE_UPD_MASK) == SIZE_UPD_PAT)
                    begin
                        rkind_next = REP_SIZE_UPDATE;
                        add_next   = 1'b0;
                        mask       = PREFIX5_MASK;
                    end
                    else if ((b & INDEXED_BIT) != 8'h00)
                    begin
                        rkind_next = REP_INDEXED;
                        add_next   = 1'b0;
                        mask       = PREFIX7_MASK;
                    end
                    else if ((b & INCR_MASK) == INCR_PAT)
                    begin
                        rkind_next = REP_INCR;
                        add_next   = 1'b1;
                        mask       = PREFIX6_MASK;
                    end
                    else
                    begin
                        rkind_next = REP_NO_INDEX;
                        add_next   = 1'b0;
                        mask       = PREFIX4_MASK;
                    end
                    acc_next = {24'h000000, b & mask};
                    cnt_next = 3'd0;
                    v        = {24'h000000, b & mask};
                    if ((b & mask) == mask)
                        phase_next = PH_REP;
                    else
                        do_rep = 1'b1;
                end
                PH_REP, PH_NLEN, PH_VLEN:
                begin
                    if (cnt_reg >= MAX_CONT || sum[35:32] != 4'h0)
                    begin
                        ev.kind  = EV_ERROR;
                        ev.err   = ERR_OVERFLOW;
                        ev.value = '0;
                        ev.hdone = 1'b1;
                        ev.hdone = 1'b0;
                        ev.add   = 1'b0;
                        ev.last  = 1'b0;
                        ev.huf   = 1'b0;
                        ev.blk_end = blk_end;
                        do_rep   = 1'b0;
                        // error flag carried via kind
                        v        = acc_reg;
                    end
                    else
                    begin
                        acc_next = sum[31:0];
                        cnt_next = cnt_reg + 3'd1;
                        v        = sum[31:0];
                        if (!b[7])
                        begin
                            if (phase_reg == PH_REP)
                                do_rep = 1'b1;
                            else
                            begin
                                do_len   = 1'b1;
                                len_name = (phase_reg == PH_NLEN);
                            end
                        end
                    end
                end
                PH_NLEN1, PH_VLEN1:
                begin
                    huf_next = b[7];
                    acc_next = {25'h0000000, b[6:0]};
                    cnt_next = 3'd0;
                    v        = {25'h0000000, b[6:0]};
                    if ({1'b0, b[6:0]} == PREFIX7_MASK)
                        phase_next = (phase_reg == PH_NLEN1) ? PH_NLEN : PH_VLEN;
                    else
                    begin
                        do_len   = 1'b1;
                        len_name = (phase_reg == PH_NLEN1);
                    end
                end
                PH_NAME, PH_VALUE:
                begin
                    ev.kind  = (phase_reg == PH_NAME) ? EV_NAME_BYTE : EV_VALUE_BYTE;
                    ev.value = {24'h000000, b};
                    ev.add   = add_reg;
                    ev.huf   = huf_reg;
                    if (remain_reg != 32'd0)
                        rem_dec = remain_reg - 32'd1;
                    remain_next = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        ev.last = 1'b1;
                        if (phase_reg == PH_NAME)
                            phase_next = PH_VLEN1;
                        else
                        begin
                            ev.hdone   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            // Prefix integer of a representation is complete
            if (do_rep)
            begin
                ev.value = v;
                case (rkind_next)
                    REP_SIZE_UPDATE:
                    begin
                        ev.kind    = EV_SIZE_UPDATE;
                        phase_next = PH_IDLE;
                    end
                    REP_INDEXED:
                    begin
                        if (v == 32'd0)
                        begin
                            ev.kind  = EV_ERROR;
                            ev.err   = ERR_ZERO_INDEX;
                            ev.value = '0;
                        end
                        else
                        begin
                            ev.kind    = EV_INDEXED;
                            ev.hdone   = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        ev.kind    = EV_LITERAL;
                        ev.add     = add_next;
                        phase_next = (v == 32'd0) ? PH_NLEN1 : PH_VLEN1;
                    end
                endcase
            end

            // String length is complete
            if (do_len)
            begin
                ev.kind     = len_name ? EV_NAME_START : EV_VALUE_START;
                ev.value    = v;
                ev.add      = add_reg;
                ev.huf      = huf_next;
                remain_next = v;
                if (v == 32'd0)
                begin
                    ev.last = 1'b1;
                    if (len_name)
                        phase_next = PH_VLEN1;
                    else
                    begin
                        ev.hdone   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                else
                    phase_next = len_name ? PH_NAME : PH_VALUE;
            end

            // Errors and block end
            if (ev.kind == EV_ERROR)
            begin
                phase_next   = PH_IDLE;
                discard_next = !blk_end;
            end
            else if (blk_end && phase_next != PH_IDLE)
            begin
                ev         = '0;
                ev.kind    = EV_ERROR;
                ev.err     = ERR_TRUNCATED;
                ev.blk_end = blk_end;
                phase_next = PH_IDLE;
            end
        end
    end

    // An event exists when one was emitted or the block ends here
    logic ev_has;
    assign ev_has = !discard_reg &&
                    (ev.kind != EV_SIZE_UPDATE || do_rep || blk_end);

    assign push       = accept && ev_has;
    assign push_event = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            rkind_reg   <= REP_SIZE_UPDATE;
            add_reg     <= 1'b0;
            huf_reg     <= 1'b0;
            remain_reg  <= '0;
            discard_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            rkind_reg   <= rkind_next;
            add_reg     <= add_next;
            huf_reg     <= huf_next;
            remain_reg  <= remain_next;
            discard_reg <= discard_next;
        end
    end

endmodule

// ===== sv/hfrp_queue.sv =====
module hfrp_queue #(
    parameter int DEPTH = hfrp_pkg::HFRP_QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  hfrp_pkg::hfrp_event_t    push_event,
    input  logic                     pop,
    output hfrp_pkg::hfrp_q_status_t status,
    output hfrp_pkg::hfrp_event_t    head
);
    import hfrp_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    hfrp_event_t     entries_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push, do_pop;

    assign status.full  = (count_reg == FullCnt);
    assign status.valid = (count_reg != '0);
    assign head         = entries_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_event;
    end

endmodule

// ===== sv/hfrp_back.sv =====
module hfrp_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  hfrp_pkg::hfrp_event_t q_head,
    output logic                  pop,
    hfrp_out_if.source            out_ch
);
    import hfrp_pkg::*;

    logic        valid_reg;
    logic [2:0]  kind_reg;
    logic [31:0] value_reg;
    logic        add_reg, huf_reg, last_reg, hdone_reg, bdone_reg;
    logic [1:0]  err_reg;
    logic        load;
    logic        is_err;

    assign load   = q_valid && (!valid_reg || out_ch.ready);
    assign pop    = load;
    assign is_err = (q_head.kind == EV_ERROR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ch.ready)
            valid_reg <= 1'b0;
    end

    // Error events carry only the code; block_done only on clean ends
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= q_head.kind;
            value_reg <= is_err ? 32'd0 : q_head.value;
            add_reg   <= !is_err && q_head.add;
            huf_reg   <= !is_err && q_head.huf;
            last_reg  <= !is_err && q_head.last;
            hdone_reg <= !is_err && q_head.hdone;
            bdone_reg <= !is_err && q_head.blk_end;
            err_reg   <= is_err ? q_head.err : ERR_NONE;
        end
    end

    assign out_ch.valid          = valid_reg;
    assign out_ch.event_kind     = kind_reg;
    assign out_ch.out_value      = value_reg;
    assign out_ch.add_to_table   = add_reg;
    assign out_ch.huffman_coded  = huf_reg;
    assign out_ch.last_of_string = last_reg;
    assign out_ch.header_done    = hdone_reg;
    assign out_ch.block_done     = bdone_reg;
    assign out_ch.error_code     = err_reg;

endmodule

// ===== sv/hpack_field_representation_parser_top.sv =====
// HPACK field representation parser, one header block byte per transaction.
// Each result is written into the queue when its byte is accepted, then loaded
// into the output register. Throughput: 1 byte per cycle unless the queue is full,
// set by the parse state update in the front.
// Reset (rst_n, async, active low): parser idle, queue empty, no result pending.
// Bytes that only extend an integer, and bytes skipped after an error, give no result.
module hpack_field_representation_parser_top #(
    parameter int QUEUE_DEPTH = hfrp_pkg::HFRP_QUEUE_DEPTH
) (
    input logic        clk,
    input logic        rst_n,
    hfrp_in_if.sink    in_ch,
    hfrp_out_if.source out_ch
);
    import hfrp_pkg::*;

    // Front: classifies each byte and updates the parse state in the
    // accepting cycle, then pushes an event into the queue.
    // Queue: decouples the parser from output backpressure.
    // Back: output register that formats and holds the result transaction.
    logic           q_push;
    hfrp_event_t    q_push_event;
    logic           q_pop;
    hfrp_q_status_t q_status;
    hfrp_event_t    q_head;

    hfrp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .q_full     (q_status.full),
        .push       (q_push),
        .push_event (q_push_event)
    );

    hfrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_event (q_push_event),
        .pop        (q_pop),
        .status     (q_status),
        .head       (q_head)
    );

    hfrp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_status.valid),
        .q_head  (q_head),
        .pop     (q_pop),
        .out_ch  (out_ch)
    );

    // No event is pushed into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_status.full)
        else $error("event pushed into full queue");

    // A clean block end never comes with an error
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.block_done |-> out_ch.event_kind != EV_ERROR)
        else $error("block_done on error event");

    // End of string only on string events
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.last_of_string |->
            out_ch.event_kind == EV_NAME_START || out_ch.event_kind == EV_NAME_BYTE ||
            out_ch.event_kind == EV_VALUE_START || out_ch.event_kind == EV_VALUE_BYTE)
        else $error("last_of_string on non-string event");

    // A header ends only on an indexed field or the value string
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.header_done |->
            out_ch.event_kind == EV_INDEXED || out_ch.event_kind == EV_VALUE_START ||
            out_ch.event_kind == EV_VALUE_BYTE)
        else $error("header_done on wrong event");

endmodule

// ===== test/hfrp_check_pkg.sv =====
package hfrp_check_pkg;

    import hfrp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REP_INT,
        ST_NAME_LEN_FIRST,
        ST_NAME_LEN_INT,
        ST_NAME_BYTES,
        ST_VALUE_LEN_FIRST,
        ST_VALUE_LEN_INT,
        ST_VALUE_BYTES
    } parse_state_t;

    typedef enum {INT_MORE, INT_DONE, INT_OVERFLOW} int_step_t;

    // Tracks the parse of the byte stream and holds the events still owed by the block.
    class hpack_event_tracker;
        parse_state_t state;
        logic [31:0]  acc;
        logic [2:0]   groups;
        hfrp_rep_t    rep;
        logic         add_flag;
        logic         huf_flag;
        logic [31:0]  remaining;
        bit           skipping;

        hfrp_event_t  cur;
        bit           cur_valid;
        hfrp_event_t  pending_events[$];
        int           events_seen;
        int           fails;

        function new();
            state       = ST_IDLE;
            acc         = '0;
            groups      = '0;
            rep         = REP_SIZE_UPDATE;
            add_flag    = 1'b0;
            huf_flag    = 1'b0;
            remaining   = '0;
            skipping    = 1'b0;
            events_seen = 0;
            fails       = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void emit(hfrp_kind_t kind, logic [31:0] value);
            cur       = '0;
            cur.kind  = kind;
            cur.value = value;
            cur_valid = 1'b1;
        endfunction

        function void emit_error(hfrp_err_t code);
            emit(EV_ERROR, 32'd0);
            cur.err = code;
        endfunction

        // One 7-bit group, least significant first
        function int_step_t extend_int(logic [7:0] b);
            logic [63:0] sum;
            if (groups >= MAX_CONT)
                return INT_OVERFLOW;
            sum = {32'd0, acc} + ({57'd0, b[6:0]} << (7 * groups));
            if (sum[63:32] != 32'd0)
                return INT_OVERFLOW;
            acc = sum[31:0];
            groups++;
            return b[7] ? INT_MORE : INT_DONE;
        endfunction

        function void finish_rep(logic [31:0] v);
            case (rep)
                REP_SIZE_UPDATE:
                begin
                    emit(EV_SIZE_UPDATE, v);
                    state = ST_IDLE;
                end
                REP_INDEXED:
                begin
                    if (v == 32'd0)
                        emit_error(ERR_ZERO_INDEX);
                    else
                    begin
                        emit(EV_INDEXED, v);
                        cur.hdone = 1'b1;
                        state     = ST_IDLE;
                    end
                end
                default:
                begin
                    emit(EV_LITERAL, v);
                    cur.add = add_flag;
                    state   = (v == 32'd0) ? ST_NAME_LEN_FIRST : ST_VALUE_LEN_FIRST;
                end
            endcase
        endfunction

        function void string_end(bit is_name);
            cur.last = 1'b1;
            if (is_name)
                state = ST_VALUE_LEN_FIRST;
            else
            begin
                cur.hdone = 1'b1;
                state     = ST_IDLE;
            end
        endfunction

        function void finish_len(logic [31:0] v, bit is_name);
            if (is_name)
                emit(EV_NAME_START, v);
            else
                emit(EV_VALUE_START, v);
            cur.add   = add_flag;
            cur.huf   = huf_flag;
            remaining = v;
            if (v == 32'd0)
                string_end(is_name);
            else
                state = is_name ? ST_NAME_BYTES : ST_VALUE_BYTES;
        endfunction

        function void int_byte(logic [7:0] b, bit is_rep, bit is_name);
            int_step_t r;
            r = extend_int(b);
            if (r == INT_OVERFLOW)
                emit_error(ERR_OVERFLOW);
            else if (r == INT_DONE)
            begin
                if (is_rep)
                    finish_rep(acc);
                else
                    finish_len(acc, is_name);
            end
        endfunction

        function void len_first(logic [7:0] b, bit is_name);
            huf_flag = b[7];
            acc      = {25'd0, b[6:0]};
            groups   = '0;
            if (b[6:0] == PREFIX7_MASK[6:0])
                state = is_name ? ST_NAME_LEN_INT : ST_VALUE_LEN_INT;
            else
                finish_len(acc, is_name);
        endfunction

        function void string_byte(logic [7:0] b, bit is_name);
            if (is_name)
                emit(EV_NAME_BYTE, {24'd0, b});
            else
                emit(EV_VALUE_BYTE, {24'd0, b});
            cur.add = add_flag;
            cur.huf = huf_flag;
            if (remaining > 32'd0)
                remaining--;
            if (remaining == 32'd0)
                string_end(is_name);
        endfunction

        // Returns 0 for a byte skipped after an error.
        function bit accept_byte(logic [7:0] b, logic blk_last);
            logic [7:0] mask;
            cur       = '0;
            cur_valid = 1'b0;
            if (skipping)
            begin
                if (blk_last)
                begin
                    skipping = 1'b0;
                    state    = ST_IDLE;
                end
                return 1'b0;
            end

            case (state)
                ST_IDLE:
                begin
                    add_flag = 1'b0;
                    if ((b & SIZE_UPD_MASK) == SIZE_UPD_PAT)
                    begin
                        rep  = REP_SIZE_UPDATE;
                        mask = PREFIX5_MASK;
                    end
                    else if ((b & INDEXED_BIT) != 8'd0)
                    begin
                        rep  = REP_INDEXED;
                        mask = PREFIX7_MASK;
                    end
                    else if ((b & INCR_MASK) == INCR_PAT)
                    begin
                        rep      = REP_INCR;
                        add_flag = 1'b1;
                        mask     = PREFIX6_MASK;
                    end
                    else
                    begin
                        rep  = REP_NO_INDEX;
                        mask = PREFIX4_MASK;
                    end
                    acc    = {24'd0, b & mask};
                    groups = '0;
                    if ((b & mask) == mask)
                        state = ST_REP_INT;
                    else
                        finish_rep(acc);
                end
                ST_REP_INT:         int_byte(b, 1'b1, 1'b0);
                ST_NAME_LEN_FIRST:  len_first(b, 1'b1);
                ST_NAME_LEN_INT:    int_byte(b, 1'b0, 1'b1);
                ST_NAME_BYTES:      string_byte(b, 1'b1);
                ST_VALUE_LEN_FIRST: len_first(b, 1'b0);
                ST_VALUE_LEN_INT:   int_byte(b, 1'b0, 1'b0);
                default:            string_byte(b, 1'b0);
            endcase

            if (cur_valid && cur.kind == EV_ERROR)
            begin
                state    = ST_IDLE;
                skipping = !blk_last;
            end
            else if (blk_last && state != ST_IDLE)
            begin
                emit_error(ERR_TRUNCATED);
                state = ST_IDLE;
            end
            else if (blk_last)
                cur_valid = 1'b1;

            if (cur_valid)
            begin
                cur.blk_end = blk_last && cur.kind != EV_ERROR;
                pending_events.push_back(cur);
            end
            return 1'b1;
        endfunction

        task report_mismatch(string msg);
            fails++;
            $display("mismatch: %s", msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("event %0d %s: got %h, expected %h",
                                          events_seen, name, got, want));
        endtask

        task check_event(hfrp_event_t got);
            hfrp_event_t want;
            events_seen++;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("event %0d not expected: kind %0d value %h",
                                          events_seen, got.kind, got.value));
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", got.kind, want.kind);
            compare_field("out_value", got.value, want.value);
            compare_field("add_to_table", got.add, want.add);
            compare_field("huffman_coded", got.huf, want.huf);
            compare_field("last_of_string", got.last, want.last);
            compare_field("header_done", got.hdone, want.hdone);
            compare_field("block_done", got.blk_end, want.blk_end);
            compare_field("error_code", got.err, want.err);
        endtask
    endclass

endpackage

// ===== test/hpack_field_representation_parser_top_test.sv =====
module hpack_field_representation_parser_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hfrp_pkg::*;
    import hfrp_check_pkg::*;

    // Cycles without any transaction before the run is declared hung. Longest
    // legal quiet stretch is one sender gap or one receiver stall plus the
    // pipeline, so this is far above any correct run.
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_BYTES = 500;

    logic clk;
    logic rst_n;

    hfrp_in_if  in_ch();
    hfrp_out_if out_ch();

    hpack_field_representation_parser_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    hpack_event_tracker tracker;

    // Bytes of the header block under construction
    logic [7:0] block_bytes[$];

    int   cycle_count;
    int   quiet_cycles;
    int   parsed_bytes;
    logic calm;

    hfrp_event_t seen_event;

    // One window in four runs with no gaps or stalls on either side.
    assign calm = (cycle_count % 512) < 128;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length: mostly none, some short, a few long.
    function automatic int gap_len();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Block construction
    // ------------------------------------------------------------------

    // HPACK prefix integer: first byte carries the pattern bits and an N-bit
    // prefix; a full prefix is followed by 7-bit groups, low group first.
    function automatic void put_int(logic [7:0] head, int unsigned bits, logic [31:0] v);
        logic [31:0] mask;
        logic [31:0] rest;
        mask = (32'd1 << bits) - 32'd1;
        if (v < mask)
            block_bytes.push_back(head | v[7:0]);
        else
        begin
            block_bytes.push_back(head | mask[7:0]);
            rest = v - mask;
            while (rest >= 32'd128)
            begin
                block_bytes.push_back({1'b1, rest[6:0]});
                rest = rest >> 7;
            end
            block_bytes.push_back({1'b0, rest[6:0]});
        end
    endfunction

    // Mostly small numbers, but every bit of out_value gets exercised.
    function automatic logic [31:0] rand_int();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 30);
            1:       return $urandom_range(0, 300);
            2:       return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    // Length-prefixed string, Huffman flag random. Long strings are rare since
    // each byte is one transaction.
    function automatic void put_str();
        int unsigned r;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (r < 85)
            len = $urandom_range(0, 6);
        else if (r < 97)
            len = $urandom_range(7, 40);
        else
            len = $urandom_range(120, 140);
        put_int({1'($urandom_range(0, 1)), 7'd0}, 7, len);
        repeat (len)
            block_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // One well-formed field representation of a random kind.
    function automatic void put_field();
        logic [31:0] idx;
        idx = ($urandom_range(0, 1) == 0) ? 32'd0 : rand_int();
        case ($urandom_range(0, 9))
            0, 1: put_int(SIZE_UPD_PAT, 5, rand_int());
            2, 3, 4:
            begin
                // index 0 is an error; keep it occasional
                if (idx == 32'd0 && $urandom_range(0, 9) != 0)
                    idx = 32'd1;
                put_int(INDEXED_BIT, 7, idx);
            end
            5, 6:
            begin
                put_int(INCR_PAT, 6, idx);
                if (idx == 32'd0)
                    put_str();
                put_str();
            end
            default:
            begin
                // without indexing or never indexed (bit 4)
                put_int({3'b000, 1'($urandom_range(0, 1)), 4'd0}, 4, idx);
                if (idx == 32'd0)
                    put_str();
                put_str();
            end
        endcase
    endfunction

    // Integer that cannot fit: either a sixth continuation group or a value
    // past 32 bits on the fifth group. Trailing bytes get skipped by the DUT.
    function automatic void put_overflow();
        case ($urandom_range(0, 3))
            0:       block_bytes.push_back(8'hff);
            1:       block_bytes.push_back(8'h7f);
            2:       block_bytes.push_back(8'h3f);
            default: block_bytes.push_back(8'h0f);
        endcase
        if ($urandom_range(0, 1) == 0)
        begin
            repeat (5)
                block_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
            block_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat (4)
                block_bytes.push_back(8'hff);
            block_bytes.push_back({1'($urandom_range(0, 1)), 7'($urandom_range(16, 127))});
        end
        repeat ($urandom_range(0, 3))
            block_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One input transaction. valid stays high straight into the next byte when
    // there is no gap, so it is never dropped and raised in one step.
    task automatic send_byte(logic [7:0] d, logic blk_last);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.block_end <= blk_last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (tracker.accept_byte(d, blk_last))
            parsed_bytes++;
    endtask

    // Whole block, block_end on the final byte.
    task automatic send_block();
        int n;
        n = block_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(block_bytes[i], i == n - 1);
        block_bytes.delete();
    endtask

    // Hold the sender until the output side has caught up. It waits on the clock
    // before checking, so the idle valid is not overwritten in the same step.
    task automatic wait_drain();
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls on the result channel.
    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    stall = gap_len();
            end
        end
    end

    // Result monitor: every accepted output transaction is checked in order.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            seen_event.kind    = hfrp_kind_t'(out_ch.event_kind);
            seen_event.value   = out_ch.out_value;
            seen_event.add     = out_ch.add_to_table;
            seen_event.huf     = out_ch.huffman_coded;
            seen_event.last    = out_ch.last_of_string;
            seen_event.hdone   = out_ch.header_done;
            seen_event.blk_end = out_ch.block_done;
            seen_event.err     = hfrp_err_t'(out_ch.error_code);
            tracker.check_event(seen_event);
        end
    end

    // Watchdog: ends a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("hpack_field_representation_parser_top_test: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int          keep;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'd0;
        in_ch.block_end <= 1'b0;
        rst_n           <= 1'b0;
        cycle_count     <= 0;
        quiet_cycles    <= 0;
        parsed_bytes = 0;
        tracker = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---

        // Largest size update: full prefix plus five continuation groups.
        put_int(SIZE_UPD_PAT, 5, 32'hffff_ffff);
        send_block();
        // Size update of zero, alone in its block.
        put_int(SIZE_UPD_PAT, 5, 32'd0);
        send_block();
        // Indexed field with index zero; the following byte is skipped and
        // closes the block.
        block_bytes = '{8'h80, 8'hc1};
        send_block();
        // Incremental indexing with a Huffman name of one byte, plain value
        // of one byte.
        block_bytes = '{8'h40, 8'h81, 8'haa, 8'h01, 8'h55};
        send_block();
        // Never indexed, name index 15 needs a continuation byte; empty
        // Huffman value.
        block_bytes = '{8'h1f, 8'h00, 8'h80};
        send_block();
        // Sixth continuation group, error lands on the block's last byte.
        block_bytes = '{8'hff, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_block();
        // Literal cut short by block_end: truncation.
        block_bytes = '{8'h01};
        send_block();

        // Sender holds until every result is back.
        in_ch.valid <= 1'b0;
        wait_drain();

        // --- random ---
        // Mostly well-formed blocks of a few fields; some truncated or with
        // one corrupted byte, some overflowing integers, some pure noise.
        while (parsed_bytes < RANDOM_BYTES)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                repeat ($urandom_range(1, 6))
                    block_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (r < 10)
                put_overflow();
            else
            begin
                repeat ($urandom_range(1, 4))
                    put_field();
                if (r < 20 && block_bytes.size() > 1)
                begin
                    keep = $urandom_range(1, block_bytes.size() - 1);
                    while (block_bytes.size() > keep)
                        void'(block_bytes.pop_back());
                end
                else if (r < 25)
                    block_bytes[$urandom_range(0, block_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
            end
            send_block();
            if ($urandom_range(0, 19) == 0)
            begin
                in_ch.valid <= 1'b0;
                wait_drain();
            end
        end

        in_ch.valid <= 1'b0;
        wait_drain();
        // Pipeline is 2 deep; give any stray result time to show up.
        repeat (10) @(posedge clk);

        if (tracker.fails == 0)
            $display("hpack_field_representation_parser_top_test: PASS");
        else
            $display("hpack_field_representation_parser_top_test: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/hfrp_pkg.sv
sv/hfrp_in_if.sv
sv/hfrp_out_if.sv
sv/hfrp_front.sv
sv/hfrp_queue.sv
sv/hfrp_back.sv
sv/hpack_field_representation_parser_top.sv
test/hfrp_check_pkg.sv
test/hpack_field_representation_parser_top_test.sv
